// ===== design/tpld_pkg.sv =====
`timescale 1ns / 1ps

package tpld_pkg;

  // Default timing of the PWM timer and the blink limits
  localparam int TICK_RATE_HZ_DEF     = 60000;
  localparam int MAX_FREQ_HZ_DEF      = 500;
  localparam int MIN_PERIOD_TICKS_DEF = 120;

  // Field widths
  localparam int FREQ_W  = 16;
  localparam int DUTY_W  = 7;
  localparam int TIME_W  = 16;

  // Duty is given in percent
  localparam int DUTY_MAX = 100;
  localparam int PCT_DIV  = 100;

  typedef enum logic [1:0] {
    MODE_OPEN     = 2'd0,
    MODE_CLOSE    = 2'd1,
    MODE_MS_TICK  = 2'd2,
    MODE_PWM_TICK = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_FREQ,
    ST_MUL,
    ST_DIV_PCT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [FREQ_W-1:0]  freq_hz;
    logic [15:0]        duty_pct;
    logic [TIME_W-1:0]  on_time_ms;
  } in_item_t;

  typedef struct packed {
    logic              pin_level;
    logic              pwm_active;
    logic [TIME_W-1:0] time_left;
  } out_item_t;

endpackage

// ===== design/tpld_div.sv =====
`timescale 1ns / 1ps

module tpld_div #(
  parameter int N = 23,
  parameter int D = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [D-1:0]  rem_r, rem_nxt;
  logic [D-1:0]  dvs_r, dvs_nxt;
  logic [N-1:0]  quo_r, quo_nxt;

  logic [D:0]    rem_sh;
  logic [D:0]    rem_sub;
  logic          ge;

  // One quotient bit per cycle, restoring form
  always_comb begin
    rem_sh  = {rem_r, quo_r[N-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(N);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
      quo_nxt = {quo_r[N-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/tpld_mul.sv =====
`timescale 1ns / 1ps

module tpld_mul #(
  parameter int AW = 16,
  parameter int BW = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  output logic              done,
  output logic [AW+BW-1:0]  product
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [PW-1:0] mcand_r, mcand_nxt;
  logic [BW-1:0] mplier_r, mplier_nxt;

  // Shift and add, one multiplier bit per cycle
  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;

    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = CW'(BW);
      acc_nxt    = '0;
      mcand_nxt  = PW'(a);
      mplier_nxt = b;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[PW-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[BW-1:1]};
      cnt_nxt    = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== design/timed_pwm_led_driver.sv =====
`timescale 1ns / 1ps

// Channel  Ports                          Payload
// in       in_valid, in_stall, in_item    tpld_pkg::in_item_t (mode, freq, duty, on-time)
// out      out_valid, out_stall, out_item tpld_pkg::out_item_t (pin, pwm flag, time left)
//
// Close, tick items and an open with zero frequency are handled in the idle state.
// Any other open runs a bit-serial divider twice and a serial multiplier
// once, through the states DIV_FREQ, MUL, DIV_PCT and EMIT.
// Reset is synchronous and active low; it leaves the LED off and PWM off.
// A stalled result waits in the output register; the next item is taken
// once that register is free or being drained and no open is being computed.

module timed_pwm_led_driver #(
  parameter int TICK_RATE_HZ     = tpld_pkg::TICK_RATE_HZ_DEF,
  parameter int MAX_FREQ_HZ      = tpld_pkg::MAX_FREQ_HZ_DEF,
  parameter int MIN_PERIOD_TICKS = tpld_pkg::MIN_PERIOD_TICKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpld_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tpld_pkg::out_item_t out_item
);

  localparam int PERIOD_MAX = (TICK_RATE_HZ > MIN_PERIOD_TICKS) ? TICK_RATE_HZ
                                                                : MIN_PERIOD_TICKS;
  localparam int CNT_W  = $clog2(PERIOD_MAX + 1);
  localparam int PROD_W = CNT_W + tpld_pkg::DUTY_W;
  localparam int FW     = tpld_pkg::FREQ_W;
  localparam int DW     = tpld_pkg::DUTY_W;
  localparam int TW     = tpld_pkg::TIME_W;

  tpld_pkg::state_t state_r, state_nxt;

  logic [TW-1:0]    rem_r, rem_nxt;
  logic             pwm_on_r, pwm_on_nxt;
  logic             static_r, static_nxt;
  logic [CNT_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0] cmp_r, cmp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] period_r, period_nxt;
  logic [DW-1:0]    duty_r, duty_nxt;

  logic                out_valid_r, out_valid_nxt;
  tpld_pkg::out_item_t out_item_r, out_item_nxt;

  logic              in_acc;
  logic              out_free;
  logic              res_load;
  logic [FW-1:0]     freq_c;
  logic [DW-1:0]     duty_c;

  logic              div_start;
  logic [PROD_W-1:0] div_dividend;
  logic [FW-1:0]     div_divisor;
  logic              div_done;
  logic [PROD_W-1:0] div_quotient;
  logic [CNT_W-1:0]  quo_low;

  logic              mul_start;
  logic              mul_done;
  logic [PROD_W-1:0] mul_product;

  tpld_div #(
    .N (PROD_W),
    .D (FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  tpld_mul #(
    .AW (CNT_W),
    .BW (DW)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (period_nxt),
    .b       (duty_r),
    .done    (mul_done),
    .product (mul_product)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != tpld_pkg::ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign freq_c  = (in_item.freq_hz > FW'(MAX_FREQ_HZ)) ? FW'(MAX_FREQ_HZ) : in_item.freq_hz;
  assign duty_c  = (in_item.duty_pct > 16'(tpld_pkg::DUTY_MAX)) ? DW'(tpld_pkg::DUTY_MAX)
                                                                : in_item.duty_pct[DW-1:0];
  assign quo_low = div_quotient[CNT_W-1:0];

  // Divider operands: tick rate by frequency at open, product by 100 later
  always_comb begin
    if (state_r == tpld_pkg::ST_MUL) begin
      div_dividend = mul_product;
      div_divisor  = FW'(tpld_pkg::PCT_DIV);
    end else begin
      div_dividend = PROD_W'(TICK_RATE_HZ);
      div_divisor  = freq_c;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rem_nxt    = rem_r;
    pwm_on_nxt = pwm_on_r;
    static_nxt = static_r;
    top_nxt    = top_r;
    cmp_nxt    = cmp_r;
    cnt_nxt    = cnt_r;
    period_nxt = period_r;
    duty_nxt   = duty_r;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    res_load   = 1'b0;

    unique case (state_r)
      tpld_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_item.mode)
            tpld_pkg::MODE_OPEN: begin
              rem_nxt = in_item.on_time_ms;
              if (in_item.freq_hz == '0) begin
                pwm_on_nxt = 1'b0;
                static_nxt = 1'b0;
                res_load   = 1'b1;
              end else begin
                duty_nxt  = duty_c;
                div_start = 1'b1;
                state_nxt = tpld_pkg::ST_DIV_FREQ;
              end
            end
            tpld_pkg::MODE_CLOSE: begin
              pwm_on_nxt = 1'b0;
              static_nxt = 1'b1;
              res_load   = 1'b1;
            end
            tpld_pkg::MODE_MS_TICK: begin
              if (rem_r != '0) begin
                rem_nxt = rem_r - TW'(1);
                // close when the on-time runs out
                if (rem_r == TW'(1)) begin
                  pwm_on_nxt = 1'b0;
                  static_nxt = 1'b1;
                end
              end
              res_load = 1'b1;
            end
            tpld_pkg::MODE_PWM_TICK: begin
              cnt_nxt  = (cnt_r >= top_r) ? '0 : cnt_r + CNT_W'(1);
              res_load = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      tpld_pkg::ST_DIV_FREQ: begin
        if (div_done) begin
          period_nxt = (quo_low < CNT_W'(MIN_PERIOD_TICKS)) ? CNT_W'(MIN_PERIOD_TICKS)
                                                            : quo_low;
          mul_start  = 1'b1;
          state_nxt  = tpld_pkg::ST_MUL;
        end
      end
      tpld_pkg::ST_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = tpld_pkg::ST_DIV_PCT;
        end
      end
      tpld_pkg::ST_DIV_PCT: begin
        if (div_done) begin
          top_nxt    = period_r - CNT_W'(1);
          // a compare of zero counts as one
          cmp_nxt    = (quo_low == '0) ? '0 : quo_low - CNT_W'(1);
          cnt_nxt    = '0;
          pwm_on_nxt = 1'b1;
          state_nxt  = tpld_pkg::ST_EMIT;
        end
      end
      tpld_pkg::ST_EMIT: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = tpld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tpld_pkg::ST_IDLE;
      end
    endcase
  end

  // Result reflects the state after the item's update
  always_comb begin
    out_item_nxt.pin_level  = pwm_on_nxt ? !(cnt_nxt < cmp_nxt) : static_nxt;
    out_item_nxt.pwm_active = pwm_on_nxt;
    out_item_nxt.time_left  = rem_nxt;

    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpld_pkg::ST_IDLE;
      rem_r       <= '0;
      pwm_on_r    <= 1'b0;
      static_r    <= 1'b1;
      top_r       <= CNT_W'(MIN_PERIOD_TICKS - 1);
      cmp_r       <= CNT_W'(MIN_PERIOD_TICKS - 1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      pwm_on_r    <= pwm_on_nxt;
      static_r    <= static_nxt;
      top_r       <= top_nxt;
      cmp_r       <= cmp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    period_r <= period_nxt;
    duty_r   <= duty_nxt;
    if (res_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tpld_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tpld_pkg::out_item_t out_item;

  // Result-side idling is switched between calm and busy stretches
  bit          stall_calm = 1'b0;
  // Input-side gaps follow the same idea per burst of stimulus
  bit          gap_calm = 1'b0;
  int unsigned items_sent = 0;

  timed_pwm_led_driver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  class led_scoreboard;
    tpld_pkg::out_item_t expected_outputs[$];
    int unsigned errors;
    logic [15:0] ms_left;
    logic        led_pwm_on;
    logic        idle_level;
    logic [19:0] period_last;
    logic [19:0] compare_at;
    logic [19:0] tick_count;

    function new();
      errors      = 0;
      ms_left     = '0;
      led_pwm_on  = 1'b0;
      idle_level  = 1'b1;
      period_last = 20'(tpld_pkg::MIN_PERIOD_TICKS_DEF - 1);
      compare_at  = 20'(tpld_pkg::MIN_PERIOD_TICKS_DEF - 1);
      tick_count  = '0;
    endfunction

    function void shut_led();
      led_pwm_on = 1'b0;
      idle_level = 1'b1;
    endfunction

    // Advance the LED state by one transfer and return the expected result after it
    function tpld_pkg::out_item_t advance_led(tpld_pkg::in_item_t it);
      int unsigned f;
      int unsigned d;
      int unsigned per;
      int unsigned c;
      tpld_pkg::out_item_t r;
      case (it.mode)
        tpld_pkg::MODE_OPEN: begin
          ms_left = it.on_time_ms;
          if (it.freq_hz == 16'd0) begin
            led_pwm_on = 1'b0;
            idle_level = 1'b0;
          end else begin
            f = 32'(it.freq_hz);
            if (f > tpld_pkg::MAX_FREQ_HZ_DEF) f = tpld_pkg::MAX_FREQ_HZ_DEF;
            d = 32'(it.duty_pct);
            if (d > tpld_pkg::DUTY_MAX) d = tpld_pkg::DUTY_MAX;
            per = tpld_pkg::TICK_RATE_HZ_DEF / f;
            if (per < tpld_pkg::MIN_PERIOD_TICKS_DEF) per = tpld_pkg::MIN_PERIOD_TICKS_DEF;
            c = d * per / tpld_pkg::PCT_DIV;
            if (c == 0) c = 1;
            period_last = 20'(per - 1);
            compare_at  = 20'(c - 1);
            tick_count  = '0;
            led_pwm_on  = 1'b1;
          end
        end
        tpld_pkg::MODE_CLOSE: shut_led();
        tpld_pkg::MODE_MS_TICK: begin
          if (ms_left != 16'd0) begin
            ms_left = ms_left - 16'd1;
            if (ms_left == 16'd0) shut_led();
          end
        end
        tpld_pkg::MODE_PWM_TICK: begin
          // timer runs freely, PWM on or not
          if (tick_count >= period_last) tick_count = '0;
          else tick_count = tick_count + 20'd1;
        end
        default: ;
      endcase
      r.pin_level  = led_pwm_on ? ((tick_count < compare_at) ? 1'b0 : 1'b1) : idle_level;
      r.pwm_active = led_pwm_on;
      r.time_left  = ms_left;
      return r;
    endfunction

    function void note_input(tpld_pkg::in_item_t it);
      expected_outputs.push_back(advance_led(it));
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_result(tpld_pkg::out_item_t got);
      tpld_pkg::out_item_t want;
      if (expected_outputs.size() == 0) begin
        report("result with nothing pending", 32'(got.time_left), 0);
      end else begin
        want = expected_outputs.pop_front();
        if (got.pin_level !== want.pin_level)
          report("pin_level", 32'(got.pin_level), 32'(want.pin_level));
        if (got.pwm_active !== want.pwm_active)
          report("pwm_active", 32'(got.pwm_active), 32'(want.pwm_active));
        if (got.time_left !== want.time_left)
          report("time_left", 32'(got.time_left), 32'(want.time_left));
      end
    endtask
  endclass

  led_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (gap_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item after a random gap and hold it until the transfer
  task automatic send_item(tpld_pkg::in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_fields(tpld_pkg::mode_t m, logic [15:0] f, logic [15:0] d,
                             logic [15:0] t);
    tpld_pkg::in_item_t it;
    it.mode       = m;
    it.freq_hz    = f;
    it.duty_pct   = d;
    it.on_time_ms = t;
    send_item(it);
  endtask

  initial begin : result_side
    int unsigned hold;
    int unsigned r;
    int unsigned cyc;
    hold = 0;
    cyc  = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
      if (cyc % 512 == 0) stall_calm = ($urandom_range(0, 2) == 0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold = hold - 1;
      end else begin
        r = $urandom_range(0, 99);
        if (stall_calm || r < 70) begin
          out_stall <= 1'b0;
        end else if (r < 96) begin
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(8, 40);
        end
      end
    end
  end

  initial begin : stimulus
    tpld_pkg::in_item_t it;
    int unsigned        burst_len;
    int unsigned        r;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset state, steady on, auto close, clamps, duty corners
    send_fields(tpld_pkg::MODE_MS_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_fields(tpld_pkg::MODE_PWM_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fields(tpld_pkg::MODE_OPEN, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_MS_TICK, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_CLOSE, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_OPEN, 16'd0, 16'd50, 16'd2);
    send_fields(tpld_pkg::MODE_MS_TICK, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_MS_TICK, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_MS_TICK, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_OPEN, 16'hFFFF, 16'hFFFF, 16'd0);
    send_fields(tpld_pkg::MODE_PWM_TICK, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_PWM_TICK, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_OPEN, 16'd1, 16'd0, 16'hFFFF);
    send_fields(tpld_pkg::MODE_PWM_TICK, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_OPEN, 16'd500, 16'd100, 16'd1);
    send_fields(tpld_pkg::MODE_MS_TICK, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_OPEN, 16'd250, 16'd50, 16'd3);
    send_fields(tpld_pkg::MODE_PWM_TICK, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_CLOSE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fields(tpld_pkg::MODE_OPEN, 16'd501, 16'd1, 16'd0);
    send_fields(tpld_pkg::MODE_PWM_TICK, 16'd0, 16'd0, 16'd0);
    send_fields(tpld_pkg::MODE_OPEN, 16'd499, 16'd101, 16'hFFFF);
    send_fields(tpld_pkg::MODE_PWM_TICK, 16'hAAAA, 16'h5555, 16'hAAAA);

    // random: an open followed by a run of ticks, with some noise mixed in
    while (items_sent < 1650) begin
      gap_calm = ($urandom_range(0, 3) == 0);
      it.mode = tpld_pkg::MODE_OPEN;
      r = $urandom_range(0, 9);
      if (r == 0) it.freq_hz = 16'd0;
      else if (r < 7) it.freq_hz = 16'($urandom_range(200, 65535));
      else if (r < 9) it.freq_hz = 16'($urandom_range(1, 200));
      else it.freq_hz = 16'($urandom());
      r = $urandom_range(0, 9);
      if (r < 4) it.duty_pct = 16'($urandom_range(0, 100));
      else if (r < 6) it.duty_pct = 16'($urandom());
      else if (r < 8) it.duty_pct = 16'($urandom_range(0, 5));
      else it.duty_pct = 16'($urandom_range(95, 100));
      r = $urandom_range(0, 9);
      if (r < 3) it.on_time_ms = 16'd0;
      else if (r < 8) it.on_time_ms = 16'($urandom_range(1, 60));
      else it.on_time_ms = 16'($urandom());
      send_item(it);
      burst_len = $urandom_range(40, 260);
      repeat (burst_len) begin
        if (items_sent < 1650) begin
          r = $urandom_range(0, 99);
          it.freq_hz    = 16'($urandom());
          it.duty_pct   = 16'($urandom());
          it.on_time_ms = 16'($urandom());
          if (r < 80) it.mode = tpld_pkg::MODE_PWM_TICK;
          else if (r < 95) it.mode = tpld_pkg::MODE_MS_TICK;
          else it.mode = tpld_pkg::mode_t'($urandom_range(0, 3));
          send_item(it);
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_outputs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== timed_pwm_led_driver.f =====
design/tpld_pkg.sv
design/tpld_div.sv
design/tpld_mul.sv
design/timed_pwm_led_driver.sv
sim/tb.sv
